@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/ljpf_pkg.sv @@
// ---------------------------------------------------------------------------
// ljpf_pkg
// Widths, payload types, register codes and the divider step function.
// ---------------------------------------------------------------------------
package ljpf_pkg;

	localparam int COORD_W    = 32;
	localparam int RES_W      = 40;
	localparam int REG_W      = 32;
	localparam int ADDR_W     = 4;
	localparam int DIFF_W     = 34;
	localparam int MAG_W      = 33;
	localparam int SQ_W       = 58;
	localparam int R2_W       = 60;
	localparam int S2_W       = 56;
	localparam int Q_W        = 30;
	localparam int DEN_W      = 60;
	localparam int QUO_W      = 40;
	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = QUO_W / DIV_BITS;

	localparam logic [1:0] REG_BOX   = 2'd0;
	localparam logic [1:0] REG_SIGMA = 2'd1;
	localparam logic [1:0] REG_EPS   = 2'd2;

	localparam logic [REG_W-1:0] BOX_RESET   = 32'd83886080;
	localparam logic [REG_W-1:0] SIGMA_RESET = 32'd16777216;
	localparam logic [REG_W-1:0] EPS_RESET   = 32'd16777216;

	// Largest positive result and magnitude of the most negative result.
	localparam logic [RES_W-1:0] POS_LIM = {1'b0, {(RES_W-1){1'b1}}};
	localparam logic [RES_W-1:0] NEG_MAG = {1'b1, {(RES_W-1){1'b0}}};

	typedef struct packed {
		logic [COORD_W-1:0] first_x;
		logic [COORD_W-1:0] first_y;
		logic [COORD_W-1:0] first_z;
		logic [COORD_W-1:0] second_x;
		logic [COORD_W-1:0] second_y;
		logic [COORD_W-1:0] second_z;
	} pair_in_t;

	typedef struct packed {
		logic signed [RES_W-1:0] force_x;
		logic signed [RES_W-1:0] force_y;
		logic signed [RES_W-1:0] force_z;
		logic signed [RES_W-1:0] pair_energy;
		logic                    within_cutoff;
		logic                    saturated;
	} pair_out_t;

	typedef struct packed {
		logic       cut;
		logic       ovf;
		logic [2:0] neg;
		logic [2:0] nz;
	} flags_t;

	typedef struct packed {
		flags_t                  f;
		logic [2:0][MAG_W-1:0]   a;
		logic [R2_W-1:0]         r2;
	} lane_a_t;

	typedef struct packed {
		flags_t           f;
		logic             fneg;
		logic [2:0]       fovf;
		logic [RES_W-1:0] eval;
		logic             esat;
	} lane_b_t;

	// One restoring division step: returns the quotient bit over the new remainder.
	function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
	                                            input logic [DEN_W-1:0] den,
	                                            input logic nb);
		logic [DEN_W:0] t;
		logic [DEN_W:0] d;
		t = {rem, nb};
		d = t - {1'b0, den};
		if (t >= {1'b0, den}) begin
			div_step = {1'b1, d[DEN_W-1:0]};
		end else begin
			div_step = {1'b0, t[DEN_W-1:0]};
		end
	endfunction

endpackage

@@ rtl/core/lennard_jones_pair_force_top.sv @@
// ---------------------------------------------------------------------------
// lennard_jones_pair_force_top
// Lennard-Jones pair force and energy with minimum-image wrap and cutoff.
// ---------------------------------------------------------------------------
//
//   Channel  Handshake                     Payload
//   -------  ----------------------------  -----------------------------
//   in       in_valid / in_ready           in_data  (pair_in_t)
//   out      out_valid / out_ready         out_data (pair_out_t)
//   config   psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One pair transfer can be taken every cycle while the skid register is empty.
// Its result passes through five front stages, a 20-stage ratio divider, ten
// multiply stages, a 20-stage force divider and the output register to out_valid.
// Reset (arst_n low) empties the pipeline and loads the default box, sigma
// and epsilon. When the consumer stalls, a skid register catches the one
// result in flight and the whole pipeline then holds until it drains.
//
module lennard_jones_pair_force_top
	import ljpf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pair_in_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pair_out_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output logic [REG_W-1:0]  prdata,
	output logic              pready
);

`include "assert_macros.svh"

	// Configuration registers. The user must write them only while the pipeline is empty; the block does not enforce it.
	logic [REG_W-1:0] box_q;
	logic [REG_W-1:0] sigma_q;
	logic [REG_W-1:0] eps_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q   <= BOX_RESET;
			sigma_q <= SIGMA_RESET;
			eps_q   <= EPS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_BOX:   box_q   <= pwdata;
				REG_SIGMA: sigma_q <= pwdata;
				REG_EPS:   eps_q   <= pwdata;
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_BOX:   prdata = box_q;
			REG_SIGMA: prdata = sigma_q;
			REG_EPS:   prdata = eps_q;
			default:   prdata = '0;
		endcase
	end

	// The whole pipeline advances together. It holds only while the skid
	// register is occupied, which keeps in_ready a registered signal.
	logic      en;
	logic      acc;
	logic      out_v_q;
	logic      skid_v_q;
	pair_out_t out_q;
	pair_out_t skid_q;

	assign en       = !skid_v_q;
	assign in_ready = en;
	assign acc      = in_valid && en;

	// Stage 1: raw separations.
	logic [COORD_W-1:0]       fc [3];
	logic [COORD_W-1:0]       sc [3];
	logic                     v_s1;
	logic signed [DIFF_W-1:0] d_s1 [3];

	assign fc[0] = in_data.first_x;
	assign fc[1] = in_data.first_y;
	assign fc[2] = in_data.first_z;
	assign sc[0] = in_data.second_x;
	assign sc[1] = in_data.second_y;
	assign sc[2] = in_data.second_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= $signed({2'b00, fc[i]}) - $signed({2'b00, sc[i]});
			end
		end
	end

	// Stage 2: a single minimum-image wrap per axis. The compare of 2d against
	// the box length is exact, one bit wider than the separation.
	logic                     v_s2;
	logic signed [DIFF_W-1:0] d_s2 [3];
	logic signed [DIFF_W:0]   two_d [3];
	logic signed [DIFF_W:0]   box_w;
	logic signed [DIFF_W-1:0] box_d;

	assign box_w = $signed({3'b000, box_q});
	assign box_d = $signed({2'b00, box_q});

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			two_d[i] = {d_s1[i], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (two_d[i] > box_w) begin
					d_s2[i] <= d_s1[i] - box_d;
				end else if (two_d[i] < -box_w) begin
					d_s2[i] <= d_s1[i] + box_d;
				end else begin
					d_s2[i] <= d_s1[i];
				end
			end
		end
	end

	// Stage 3: magnitude and sign of each wrapped separation. After one wrap
	// the magnitude always stays below 2^33.
	logic              v_s3;
	logic [MAG_W-1:0]  a_s3 [3];
	logic [2:0]        neg_s3;
	logic [2:0]        nz_s3;
	logic [DIFF_W-1:0] ab [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ab[i] = d_s2[i][DIFF_W-1] ? DIFF_W'(-d_s2[i]) : DIFF_W'(d_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s3[i]   <= ab[i][MAG_W-1:0];
				neg_s3[i] <= d_s2[i][DIFF_W-1];
				nz_s3[i]  <= (d_s2[i] != '0);
			end
		end
	end

	// Stage 4: squares in Q.40 (four fraction bits dropped before squaring).
	logic             v_s4;
	logic [SQ_W-1:0]  sq_s4 [3];
	logic [S2_W-1:0]  s2_s4;
	logic [MAG_W-1:0] a_s4 [3];
	logic [2:0]       neg_s4;
	logic [2:0]       nz_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= SQ_W'(a_s3[i][MAG_W-1:4]) * SQ_W'(a_s3[i][MAG_W-1:4]);
				a_s4[i]  <= a_s3[i];
			end
			s2_s4  <= S2_W'(sigma_q[REG_W-1:4]) * S2_W'(sigma_q[REG_W-1:4]);
			neg_s4 <= neg_s3;
			nz_s4  <= nz_s3;
		end
	end

	// Stage 5: squared distance.
	logic             v_s5;
	logic [R2_W-1:0]  r2_s5;
	logic [S2_W-1:0]  s2_s5;
	logic [MAG_W-1:0] a_s5 [3];
	logic [2:0]       neg_s5;
	logic [2:0]       nz_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s5  <= R2_W'(sq_s4[0]) + R2_W'(sq_s4[1]) + R2_W'(sq_s4[2]);
			s2_s5  <= s2_s4;
			a_s5   <= a_s4;
			neg_s5 <= neg_s4;
			nz_s5  <= nz_s4;
		end
	end

	// Cutoff test (4 r2 < 25 s2) and ratio overflow test (s2 >= 64 r2). The
	// ratio s2 / r2 in Q.24 enters its divider here; the top 40 bits of the
	// shifted numerator form the starting remainder.
	logic [R2_W+1:0] r2x4;
	logic [R2_W+1:0] s2x25;
	logic [R2_W+5:0] r2x64;
	logic            cut_c;
	logic            ovf_c;
	lane_a_t         lane_a_in;
	logic [QUO_W-1:0] quo_a;

	assign r2x4  = {r2_s5, 2'b00};
	assign s2x25 = (R2_W+2)'({s2_s5, 4'b0000}) + (R2_W+2)'({s2_s5, 3'b000})
	             + (R2_W+2)'(s2_s5);
	assign r2x64 = {r2_s5, 6'b000000};
	assign cut_c = r2x4 < s2x25;
	assign ovf_c = (R2_W+6)'(s2_s5) >= r2x64;

	always_comb begin
		lane_a_in.f.cut = cut_c;
		lane_a_in.f.ovf = ovf_c;
		lane_a_in.f.neg = neg_s5;
		lane_a_in.f.nz  = nz_s5;
		for (int i = 0; i < 3; i++) begin
			lane_a_in.a[i] = a_s5[i];
		end
		lane_a_in.r2 = r2_s5;
	end

	ljpf_div u_ratio_div (
		.clk     (clk),
		.en      (en),
		.rem_in  (DEN_W'(s2_s5[S2_W-1:16])),
		.num_in  ({s2_s5[15:0], 24'd0}),
		.den_in  (r2_s5),
		.quo_out (quo_a)
	);

	// Side data that travels beside the ratio divider.
	logic    lane_a_v_sd [DIV_STAGES];
	lane_a_t lane_a_sd   [DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			lane_a_sd[0] <= lane_a_in;
			for (int k = 1; k < DIV_STAGES; k++) begin
				lane_a_sd[k] <= lane_a_sd[k-1];
			end
		end
	end

	lane_a_t la;
	assign la = lane_a_sd[DIV_STAGES-1];

	// Stage 6: q squared.
	logic            v_s6;
	lane_a_t         la_s6;
	logic [Q_W-1:0]  q_s6;
	logic [59:0]     qq_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			la_s6 <= la;
			q_s6  <= quo_a[Q_W-1:0];
			qq_s6 <= 60'(quo_a[Q_W-1:0]) * 60'(quo_a[Q_W-1:0]);
		end
	end

	// Stage 7: q cubed, before the Q.24 rescale.
	logic        v_s7;
	lane_a_t     la_s7;
	logic [65:0] q3p_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			la_s7  <= la_s6;
			q3p_s7 <= 66'(qq_s6[59:24]) * 66'(q_s6);
		end
	end

	// Stage 8: q^6 as three partial products of q^3 halves.
	logic        v_s8;
	lane_a_t     la_s8;
	logic [41:0] q3_s8;
	logic [41:0] hh_s8;
	logic [41:0] hl_s8;
	logic [41:0] ll_s8;
	logic [41:0] q3_c;

	assign q3_c = q3p_s7[65:24];

	always_ff @(posedge clk) begin
		if (en) begin
			la_s8 <= la_s7;
			q3_s8 <= q3_c;
			hh_s8 <= 42'(q3_c[41:21]) * 42'(q3_c[41:21]);
			hl_s8 <= 42'(q3_c[41:21]) * 42'(q3_c[20:0]);
			ll_s8 <= 42'(q3_c[20:0]) * 42'(q3_c[20:0]);
		end
	end

	// Stage 9: partial products summed into q^6.
	logic        v_s9;
	lane_a_t     la_s9;
	logic [41:0] q3_s9;
	logic [59:0] q6_s9;
	logic [83:0] q6_full;

	assign q6_full = {hh_s8, 42'd0} + 84'({hl_s8, 22'd0}) + 84'(ll_s8);

	always_ff @(posedge clk) begin
		if (en) begin
			la_s9 <= la_s8;
			q3_s9 <= q3_s8;
			q6_s9 <= q6_full[83:24];
		end
	end

	// Stage 10: sign and magnitude of (q6 - q3) and (2 q6 - q3).
	logic        v_s10;
	lane_a_t     la_s10;
	logic        eneg_s10;
	logic        fneg_s10;
	logic [59:0] em_s10;
	logic [60:0] fm_s10;
	logic [59:0] q3_e;
	logic [60:0] q3_f;
	logic [60:0] q6x2;

	assign q3_e = 60'(q3_s9);
	assign q3_f = 61'(q3_s9);
	assign q6x2 = {q6_s9, 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			la_s10   <= la_s9;
			eneg_s10 <= q6_s9 < q3_e;
			em_s10   <= (q6_s9 < q3_e) ? q3_e - q6_s9 : q6_s9 - q3_e;
			fneg_s10 <= q6x2 < q3_f;
			fm_s10   <= (q6x2 < q3_f) ? q3_f - q6x2 : q6x2 - q3_f;
		end
	end

	// Stage 11: products with epsilon, each split into two halves.
	logic        v_s11;
	lane_a_t     la_s11;
	logic        eneg_s11;
	logic        fneg_s11;
	logic [61:0] ehp_s11;
	logic [61:0] elp_s11;
	logic [61:0] fhp_s11;
	logic [62:0] flp_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			la_s11   <= la_s10;
			eneg_s11 <= eneg_s10;
			fneg_s11 <= fneg_s10;
			ehp_s11  <= 62'(em_s10[59:30]) * 62'(eps_q);
			elp_s11  <= 62'(em_s10[29:0]) * 62'(eps_q);
			fhp_s11  <= 62'(fm_s10[60:31]) * 62'(eps_q);
			flp_s11  <= 63'(fm_s10[30:0]) * 63'(eps_q);
		end
	end

	// Stage 12: halves recombined and rescaled from Q.48 to Q.24.
	logic        v_s12;
	lane_a_t     la_s12;
	logic        eneg_s12;
	logic        fneg_s12;
	logic [67:0] e_s12;
	logic [68:0] t_s12;
	logic [91:0] ep_full;
	logic [92:0] fp_full;

	assign ep_full = {ehp_s11, 30'd0} + 92'(elp_s11);
	assign fp_full = 93'({fhp_s11, 31'd0}) + 93'(flp_s11);

	always_ff @(posedge clk) begin
		if (en) begin
			la_s12   <= la_s11;
			eneg_s12 <= eneg_s11;
			fneg_s12 <= fneg_s11;
			e_s12    <= ep_full[91:24];
			t_s12    <= fp_full[92:24];
		end
	end

	// Stage 13: energy = 4 e clamped to the output range, and the force
	// factor G = 24 t, which saturates at 2^64 - 1.
	logic        v_s13;
	lane_a_t     la_s13;
	logic        fneg_s13;
	logic [RES_W-1:0] eval_s13;
	logic        esat_s13;
	logic [63:0] g_s13;
	logic [69:0] ev;
	logic [69:0] elim;
	logic [RES_W-1:0] emag;
	logic [73:0] t24;

	assign ev   = {e_s12, 2'b00};
	assign elim = 70'(eneg_s12 ? NEG_MAG : POS_LIM);
	assign emag = (ev > elim) ? elim[RES_W-1:0] : ev[RES_W-1:0];
	assign t24  = 74'({t_s12, 4'b0000}) + 74'({t_s12, 3'b000});

	always_ff @(posedge clk) begin
		if (en) begin
			la_s13   <= la_s12;
			fneg_s13 <= fneg_s12;
			esat_s13 <= ev > elim;
			eval_s13 <= eneg_s12 ? RES_W'(-emag) : emag;
			g_s13    <= (t24[73:64] != '0) ? {64{1'b1}} : t24[63:0];
		end
	end

	// Stage 14: G times each separation magnitude, in 32-bit halves of G.
	logic        v_s14;
	lane_a_t     la_s14;
	logic        fneg_s14;
	logic [RES_W-1:0] eval_s14;
	logic        esat_s14;
	logic [64:0] pl_s14 [3];
	logic [64:0] ph_s14 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			la_s14   <= la_s13;
			fneg_s14 <= fneg_s13;
			eval_s14 <= eval_s13;
			esat_s14 <= esat_s13;
			for (int i = 0; i < 3; i++) begin
				pl_s14[i] <= 65'(g_s13[31:0]) * 65'(la_s13.a[i]);
				ph_s14[i] <= 65'(g_s13[63:32]) * 65'(la_s13.a[i]);
			end
		end
	end

	// Stage 15: full product G |d|. The force numerator is this product
	// shifted up by 16.
	logic        v_s15;
	lane_a_t     la_s15;
	logic        fneg_s15;
	logic [RES_W-1:0] eval_s15;
	logic        esat_s15;
	logic [96:0] prod_s15 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			la_s15   <= la_s14;
			fneg_s15 <= fneg_s14;
			eval_s15 <= eval_s14;
			esat_s15 <= esat_s14;
			for (int i = 0; i < 3; i++) begin
				prod_s15[i] <= {ph_s14[i], 32'd0} + 97'(pl_s14[i]);
			end
		end
	end

	// Force dividers. Only 40 quotient bits matter: a quotient of 2^40 or
	// more always clamps, and that case is caught by comparing the upper
	// numerator bits with r2 before division.
	lane_b_t          lane_b_in;
	logic [QUO_W-1:0] quo_f [3];

	always_comb begin
		lane_b_in.f    = la_s15.f;
		lane_b_in.fneg = fneg_s15;
		lane_b_in.eval = eval_s15;
		lane_b_in.esat = esat_s15;
		for (int i = 0; i < 3; i++) begin
			lane_b_in.fovf[i] = prod_s15[i][96:24] >= 73'(la_s15.r2);
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_force_div
		ljpf_div u_force_div (
			.clk     (clk),
			.en      (en),
			.rem_in  (prod_s15[i][83:24]),
			.num_in  ({prod_s15[i][23:0], 16'd0}),
			.den_in  (la_s15.r2),
			.quo_out (quo_f[i])
		);
	end

	logic    lane_b_v_sd [DIV_STAGES];
	lane_b_t lane_b_sd   [DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			lane_b_sd[0] <= lane_b_in;
			for (int k = 1; k < DIV_STAGES; k++) begin
				lane_b_sd[k] <= lane_b_sd[k-1];
			end
		end
	end

	// Valid bits for every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			for (int k = 0; k < DIV_STAGES; k++) begin
				lane_a_v_sd[k] <= 1'b0;
				lane_b_v_sd[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1           <= acc;
			v_s2           <= v_s1;
			v_s3           <= v_s2;
			v_s4           <= v_s3;
			v_s5           <= v_s4;
			lane_a_v_sd[0] <= v_s5;
			for (int k = 1; k < DIV_STAGES; k++) begin
				lane_a_v_sd[k] <= lane_a_v_sd[k-1];
				lane_b_v_sd[k] <= lane_b_v_sd[k-1];
			end
			v_s6           <= lane_a_v_sd[DIV_STAGES-1];
			v_s7           <= v_s6;
			v_s8           <= v_s7;
			v_s9           <= v_s8;
			v_s10          <= v_s9;
			v_s11          <= v_s10;
			v_s12          <= v_s11;
			v_s13          <= v_s12;
			v_s14          <= v_s13;
			v_s15          <= v_s14;
			lane_b_v_sd[0] <= v_s15;
		end
	end

	// Final clamp and result selection. Outside the cutoff everything is zero.
	// When the ratio overflows, the energy and each force on an axis with nonzero
	// separation take their limits unless epsilon is zero, in which case only within_cutoff is set.
	lane_b_t          lb;
	logic             last_v;
	pair_out_t        res;
	logic [RES_W-1:0] fval [3];
	logic [2:0]       fsat;
	logic [RES_W-1:0] flim [3];
	logic [RES_W-1:0] fmag [3];
	logic [RES_W-1:0] fovl [3];
	logic             sn [3];

	assign lb     = lane_b_sd[DIV_STAGES-1];
	assign last_v = lane_b_v_sd[DIV_STAGES-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sn[i]   = lb.fneg ^ lb.f.neg[i];
			flim[i] = sn[i] ? NEG_MAG : POS_LIM;
			fsat[i] = lb.fovf[i] || (quo_f[i] > flim[i]);
			fmag[i] = fsat[i] ? flim[i] : quo_f[i];
			fval[i] = sn[i] ? RES_W'(-fmag[i]) : fmag[i];
			if (!lb.f.nz[i]) begin
				fovl[i] = '0;
			end else if (lb.f.neg[i]) begin
				fovl[i] = NEG_MAG;
			end else begin
				fovl[i] = POS_LIM;
			end
		end

		res = '0;
		if (lb.f.cut) begin
			res.within_cutoff = 1'b1;
			if (lb.f.ovf) begin
				if (eps_q != '0) begin
					res.force_x     = fovl[0];
					res.force_y     = fovl[1];
					res.force_z     = fovl[2];
					res.pair_energy = POS_LIM;
					res.saturated   = 1'b1;
				end
			end else begin
				res.force_x     = fval[0];
				res.force_y     = fval[1];
				res.force_z     = fval[2];
				res.pair_energy = lb.eval;
				res.saturated   = lb.esat || (fsat != '0);
			end
		end
	end

	// Output register with a one-entry skid register behind it.
	logic push;

	assign push = en && last_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || out_ready) begin
			out_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_ready) begin
				out_q <= skid_q;
			end
		end else if (!out_v_q || out_ready) begin
			if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	// True when every value field and the saturation flag of the held result
	// are zero.
	logic out_zero;

	assign out_zero = out_q.force_x == '0 && out_q.force_y == '0
	               && out_q.force_z == '0 && out_q.pair_energy == '0
	               && !out_q.saturated;

	// The skid register is only ever filled behind a held output.
	`ASSERT_IMP(a_skid_behind_out, skid_v_q, out_v_q)
	// A parked result in the skid register survives a stalled cycle intact.
	`ASSERT_NXT(a_skid_hold, skid_v_q && !out_ready, skid_v_q && $stable(skid_q))
	// A pair outside the cutoff leaves every value field and flag at zero.
	`ASSERT_IMP(a_far_zero, out_v_q && !out_q.within_cutoff, out_zero)

endmodule

@@ rtl/core/ljpf_div.sv @@
// ---------------------------------------------------------------------------
// ljpf_div
// Pipelined restoring divider, a fixed number of quotient bits per stage.
// ---------------------------------------------------------------------------
module ljpf_div
	import ljpf_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [DEN_W-1:0] rem_in,
	input  logic [QUO_W-1:0] num_in,
	input  logic [DEN_W-1:0] den_in,
	output logic [QUO_W-1:0] quo_out
);

	logic [DEN_W-1:0] rem_sd [DIV_STAGES];
	logic [QUO_W-1:0] num_sd [DIV_STAGES];
	logic [DEN_W-1:0] den_sd [DIV_STAGES];
	logic [QUO_W-1:0] quo_sd [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [DEN_W-1:0] rem_p;
		logic [DEN_W-1:0] den_p;
		logic [DEN_W-1:0] rem_n;
		logic [QUO_W-1:0] num_p;
		logic [QUO_W-1:0] quo_p;
		logic [QUO_W-1:0] num_n;
		logic [QUO_W-1:0] quo_n;

		if (k == 0) begin : g_first
			assign rem_p = rem_in;
			assign num_p = num_in;
			assign den_p = den_in;
			assign quo_p = '0;
		end else begin : g_next
			assign rem_p = rem_sd[k-1];
			assign num_p = num_sd[k-1];
			assign den_p = den_sd[k-1];
			assign quo_p = quo_sd[k-1];
		end

		always_comb begin
			logic [DEN_W:0] st;
			rem_n = rem_p;
			num_n = num_p;
			quo_n = quo_p;
			st    = '0;
			for (int b = 0; b < DIV_BITS; b++) begin
				st    = div_step(rem_n, den_p, num_n[QUO_W-1]);
				rem_n = st[DEN_W-1:0];
				quo_n = {quo_n[QUO_W-2:0], st[DEN_W]};
				num_n = {num_n[QUO_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[k] <= rem_n;
				num_sd[k] <= num_n;
				den_sd[k] <= den_p;
				quo_sd[k] <= quo_n;
			end
		end
	end

	assign quo_out = quo_sd[DIV_STAGES-1];

endmodule

@@ bench/lennard_jones_pair_force_checker.sv @@
// ---------------------------------------------------------------------------
// lennard_jones_pair_force_checker
// Watches the pair, result and register channels, predicts each result and
// compares it field by field with what the block returns.
// ---------------------------------------------------------------------------
module lennard_jones_pair_force_checker
	import ljpf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  pair_in_t          in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  pair_out_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output int                fail_count,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] ALL_ONES = '1;

	logic [63:0] box_q, sigma_q, eps_q;
	pair_out_t   expected_results[$];

	// Product shifted down by 24 fraction bits, held at all ones on overflow.
	function automatic logic [63:0] mul_q24(input logic [63:0] x, input logic [63:0] y);
		logic [127:0] w;
		w = {64'd0, x} * {64'd0, y};
		if (w[127:88] != 0) begin
			return ALL_ONES;
		end
		return w[87:24];
	endfunction

	function automatic logic [63:0] mul_const(input logic [63:0] x, input logic [63:0] k);
		if (x > ALL_ONES / k) begin
			return ALL_ONES;
		end
		return x * k;
	endfunction

	// Returns {clamped, value} for a magnitude and sign at the result width.
	function automatic logic [RES_W:0] clamp_res(input logic [63:0] mag, input logic neg);
		logic [63:0] lim;
		logic        hit;
		lim = neg ? 64'(NEG_MAG) : 64'(POS_LIM);
		hit = mag > lim;
		if (hit) begin
			mag = lim;
		end
		return {hit, neg ? RES_W'(-mag) : RES_W'(mag)};
	endfunction

	function automatic pair_out_t pair_force_predict(input pair_in_t p, input logic [63:0] box,
	                                                 input logic [63:0] sig,
	                                                 input logic [63:0] eps);
		longint       sep[3];
		logic [63:0]  mag_d[3];
		logic [63:0]  firsts[3], seconds[3];
		logic [RES_W:0] cl[4];
		logic [63:0]  r2, s2, sg, q, q2, q3, q6, mag, g;
		logic [127:0] w;
		logic         far, sat, eneg, fneg;
		pair_out_t    o;
		firsts  = '{64'(p.first_x), 64'(p.first_y), 64'(p.first_z)};
		seconds = '{64'(p.second_x), 64'(p.second_y), 64'(p.second_z)};
		o = '0;
		far = 1'b0;
		sat = 1'b0;
		r2 = 0;
		for (int i = 0; i < 3; i++) begin
			sep[i] = longint'(firsts[i]) - longint'(seconds[i]);
			if (2 * sep[i] > longint'(box)) begin
				sep[i] -= longint'(box);
			end else if (2 * sep[i] < -longint'(box)) begin
				sep[i] += longint'(box);
			end
			mag_d[i] = sep[i] < 0 ? 64'(-sep[i]) : 64'(sep[i]);
			if (mag_d[i] >= 64'd1 << 34) begin
				far = 1'b1;
			end
		end
		if (far) begin
			return o;
		end
		for (int i = 0; i < 3; i++) begin
			r2 += (mag_d[i] >> 4) * (mag_d[i] >> 4);
		end
		sg = sig >> 4;
		s2 = sg * sg;
		// The compare is taken at 64 bits, where neither product can wrap.
		if (!(64'(4 * r2) < 64'(25 * s2))) begin
			return o;
		end
		o.within_cutoff = 1'b1;
		if (r2 == 0 || s2 / r2 >= 64) begin
			if (eps == 0) begin
				return o;
			end
			cl[3] = clamp_res(ALL_ONES, 1'b0);
			o.pair_energy = cl[3][RES_W-1:0];
			sat = cl[3][RES_W];
			for (int i = 0; i < 3; i++) begin
				cl[i] = '0;
				if (sep[i] != 0) begin
					cl[i] = clamp_res(ALL_ONES, sep[i] < 0);
					sat |= cl[i][RES_W];
				end
			end
			o.force_x = cl[0][RES_W-1:0];
			o.force_y = cl[1][RES_W-1:0];
			o.force_z = cl[2][RES_W-1:0];
			o.saturated = sat;
			return o;
		end
		w = ({64'd0, s2} << 24) / {64'd0, r2};
		q = w[63:0];
		q2 = mul_q24(q, q);
		q3 = mul_q24(q2, q);
		q6 = mul_q24(q3, q3);
		eneg = q6 < q3;
		mag = eneg ? q3 - q6 : q6 - q3;
		mag = mul_const(mul_q24(mag, eps), 64'd4);
		cl[3] = clamp_res(mag, eneg);
		fneg = 64'(2 * q6) < q3;
		mag = fneg ? q3 - 64'(2 * q6) : 64'(2 * q6) - q3;
		g = mul_const(mul_q24(mag, eps), 64'd24);
		for (int i = 0; i < 3; i++) begin
			w = {64'd0, g} * {64'd0, mag_d[i] << 16};
			if (w[127:64] >= r2) begin
				mag = ALL_ONES;
			end else begin
				mag = 64'(w / {64'd0, r2});
			end
			cl[i] = clamp_res(mag, fneg != (sep[i] < 0));
		end
		o.force_x = cl[0][RES_W-1:0];
		o.force_y = cl[1][RES_W-1:0];
		o.force_z = cl[2][RES_W-1:0];
		o.pair_energy = cl[3][RES_W-1:0];
		o.saturated = cl[0][RES_W] | cl[1][RES_W] | cl[2][RES_W] | cl[3][RES_W];
		return o;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		pair_out_t want;
		int        errs;
		errs = 0;
		if (!arst_n) begin
			box_q <= 64'(BOX_RESET);
			sigma_q <= 64'(SIGMA_RESET);
			eps_q <= 64'(EPS_RESET);
			fail_count <= 0;
			expected_results.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_BOX: box_q <= 64'(pwdata);
					REG_SIGMA: sigma_q <= 64'(pwdata);
					REG_EPS: eps_q <= 64'(pwdata);
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				expected_results.push_back(pair_force_predict(in_data, box_q, sigma_q, eps_q));
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no pair outstanding");
					errs++;
				end else begin
					want = expected_results.pop_front();
					if (out_data.force_x !== want.force_x) begin
						$error("force_x expected %0d actual %0d", want.force_x, out_data.force_x);
						errs++;
					end
					if (out_data.force_y !== want.force_y) begin
						$error("force_y expected %0d actual %0d", want.force_y, out_data.force_y);
						errs++;
					end
					if (out_data.force_z !== want.force_z) begin
						$error("force_z expected %0d actual %0d", want.force_z, out_data.force_z);
						errs++;
					end
					if (out_data.pair_energy !== want.pair_energy) begin
						$error("pair_energy expected %0d actual %0d", want.pair_energy,
							out_data.pair_energy);
						errs++;
					end
					if (out_data.within_cutoff !== want.within_cutoff) begin
						$error("within_cutoff expected %0b actual %0b", want.within_cutoff,
							out_data.within_cutoff);
						errs++;
					end
					if (out_data.saturated !== want.saturated) begin
						$error("saturated expected %0b actual %0b", want.saturated,
							out_data.saturated);
						errs++;
					end
				end
			end
			if (errs != 0) begin
				fail_count <= fail_count + errs;
			end
		end
	end

endmodule

@@ bench/lennard_jones_pair_force_top_tb.sv @@
// ---------------------------------------------------------------------------
// lennard_jones_pair_force_top_tb
// Drives particle pairs and register settings into the pair force block,
// with random idling and back-pressure, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module lennard_jones_pair_force_top_tb;
	import ljpf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Settling time after the last result is back, longer than the block's pipeline.
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam logic [31:0] ONE = 32'd16777216;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	pair_in_t          in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	pair_out_t         out_data;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [REG_W-1:0]  pwdata = '0;
	logic [REG_W-1:0]  prdata;
	logic              pready;
	int                fail_count;
	int                pending;

	// Knobs shared by the sender and the receiver processes, and the watchdog's cycle count.
	bit                steady = 1'b0;
	bit                hold_request = 1'b0;
	int                cycle_count = 0;

	// Box and sigma as the sender last wrote them.
	logic [31:0]       box_now = BOX_RESET;
	logic [31:0]       sigma_now = SIGMA_RESET;

	always #4 clk = ~clk;

	lennard_jones_pair_force_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	lennard_jones_pair_force_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.fail_count(fail_count), .pending(pending)
	);

	// A runaway run is cut off here and counted as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("lennard_jones_pair_force_top: mismatch");
			$finish;
		end
	end

	// The receiver stalls at random, except during the steady stretch. When
	// the sender asks for it, it holds off for a long, counted stretch so that
	// the pipeline backs up and the block drops in_ready.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= 24);
			end
		end
	end

	// A register write: setup cycle, then access cycle, then release.
	task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'({index, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Waits until every predicted result has come back, then lets the
	// pipeline settle before the registers may change. The first edge lets
	// the checker record a transfer taken at the current edge.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_settings(input logic [31:0] box, input logic [31:0] sig,
	                             input logic [31:0] eps);
		drain_pipeline();
		reg_write(REG_BOX, box);
		reg_write(REG_SIGMA, sig);
		reg_write(REG_EPS, eps);
		box_now = box;
		sigma_now = sig;
	endtask

	// Offers one pair and holds it until the block takes the transfer; then
	// sometimes leaves a gap before the next one.
	task automatic send_pair(input pair_in_t pair);
		in_valid <= 1'b1;
		in_data <= pair;
		do @(posedge clk); while (!in_ready);
		if (!steady && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_coords(input logic [31:0] fx, input logic [31:0] fy,
	                           input logic [31:0] fz, input logic [31:0] sx,
	                           input logic [31:0] sy, input logic [31:0] sz);
		send_pair('{fx, fy, fz, sx, sy, sz});
	endtask

	// Mostly physical pairs: the first particle inside the box and the second
	// a random offset of up to three sigma away per axis, so that many pairs
	// land inside the cutoff. The rest are unrestricted coordinates.
	function automatic pair_in_t random_pair();
		pair_in_t    p;
		logic [31:0] c[6];
		logic [63:0] off;
		for (int i = 0; i < 6; i++) begin
			c[i] = $urandom;
		end
		if ($urandom_range(99) < 80) begin
			for (int i = 0; i < 3; i++) begin
				c[i] = (box_now == 0) ? 32'd0 : $urandom % box_now;
				off = (64'($urandom_range(0, 300)) * 64'(sigma_now)) / 64'd100;
				if ($urandom_range(1)) begin
					c[i + 3] = c[i] + 32'(off);
				end else begin
					c[i + 3] = c[i] - 32'(off);
				end
			end
		end
		p = '{c[0], c[1], c[2], c[3], c[4], c[5]};
		return p;
	endfunction

	task automatic send_random(input int count);
		for (int n = 0; n < count; n++) begin
			send_pair(random_pair());
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: box 5.0, sigma 1.0, epsilon 1.0.
		// Coincident particles overflow the ratio.
		send_coords(ONE, ONE, ONE, ONE, ONE, ONE);
		// One sigma apart along x, both signs, and near the potential minimum.
		send_coords(2 * ONE, ONE, ONE, ONE, ONE, ONE);
		send_coords(ONE, ONE, ONE, 2 * ONE, ONE, ONE);
		send_coords(ONE, ONE, 32'd35664100, ONE, ONE, 32'd16830000);
		// Separation wraps across the box edge in each direction.
		send_coords(32'd1677721, ONE, ONE, 32'd82208358, ONE, ONE);
		send_coords(ONE, 32'd82208358, ONE, ONE, 32'd1677721, ONE);
		// Right at the cutoff radius and just inside it.
		send_coords(ONE, ONE, ONE, ONE, ONE, ONE + 32'd41943040);
		send_coords(ONE, ONE, ONE, ONE, ONE, ONE + 32'd41943039);
		// Very close pair: large repulsion, clamped outputs.
		send_coords(ONE, ONE, ONE, ONE + 32'd3000000, ONE + 32'd100, ONE);
		// Coordinates at the field extremes, outside the box.
		send_coords('1, '1, '1, '0, '0, '0);
		send_coords('0, '0, '0, '1, '1, '1);
		send_coords('1, '1, '1, '1, '1, '1);
		// Diagonal pair with mixed signs.
		send_coords(3 * ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, ONE);
		send_random(60);

		// Long receiver stall while pairs keep coming, so the block fills.
		hold_request = 1'b1;
		send_random(90);

		// The sender pauses until every result is back, then resumes in a
		// stretch with no idling on either side.
		drain_pipeline();
		steady = 1'b1;
		send_random(60);
		steady = 1'b0;

		// Largest box, zero epsilon: every force and energy is zero.
		load_settings('1, ONE, 32'd0);
		send_coords(ONE, ONE, ONE, ONE, ONE, ONE);
		send_coords(2 * ONE, ONE, ONE, ONE, ONE, ONE);
		send_random(60);

		// Smallest box and tiny sigma: nothing is within the cutoff.
		load_settings(32'd1, 32'd15, '1);
		send_coords(ONE, ONE, ONE, ONE, ONE, ONE);
		send_random(40);

		// Huge sigma with the largest epsilon: coordinates far inside cutoff.
		load_settings(32'd167772160, '1, '1);
		send_coords(ONE, ONE, ONE, ONE, ONE, ONE);
		send_random(60);

		// Smallest sigma, then half sigma with a strong well.
		load_settings(32'd134217728, 32'd1, 32'd33554432);
		send_random(30);
		load_settings(32'd134217728, 32'd8388608, 32'hFFFF0000);
		send_coords(ONE, ONE, ONE, ONE + 32'd9000000, ONE, ONE);
		send_random(70);

		drain_pipeline();
		if (fail_count == 0) begin
			$display("lennard_jones_pair_force_top: match");
		end else begin
			$display("lennard_jones_pair_force_top: mismatch");
		end
		$finish;
	end

endmodule
